FILE: src/kehtc_pkg.sv
package kehtc_pkg;

  localparam int LEVEL_W = 16;
  localparam int KEY_W   = 8;
  localparam int HOLD_W  = 8;
  localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_HOLD  = 2'd1,
    REQ_TAP   = 2'd2,
    REQ_CHORD = 2'd3
  } req_t;

endpackage

FILE: src/kehtc_in_if.sv
interface kehtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] key_levels;
  logic [7:0]  key_a;
  logic [7:0]  key_b;
  logic [7:0]  wait_frames;

  modport source (output valid, output req_type, output key_levels, output key_a,
                  output key_b, output wait_frames, input ready);
  modport sink (input valid, input req_type, input key_levels, input key_a,
                input key_b, input wait_frames, output ready);
endinterface

FILE: src/kehtc_out_if.sv
interface kehtc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        status;
  logic [15:0] pressed_edges;
  logic [15:0] released_edges;
  logic [15:0] held_keys;

  modport source (output valid, output hit, output status, output pressed_edges,
                  output released_edges, output held_keys, input ready);
  modport sink (input valid, input hit, input status, input pressed_edges,
                input released_edges, input held_keys, output ready);
endinterface

FILE: src/kehtc_store.sv
module kehtc_store #(
  parameter int NUM_KEYS = 16,
  parameter int RW = 72,
  localparam int KW = $clog2(NUM_KEYS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [KW-1:0] ra,
  input  logic          we,
  input  logic [KW-1:0] wa,
  input  logic [RW-1:0] wd,
  output logic [RW-1:0] rq
);
  logic [RW-1:0]       mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] valid_r;
  logic [RW-1:0]       q_r;
  logic                qv_r;

  // per-key valid bits stand in for clearing the records at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else begin
      qv_r <= valid_r[ra];
      if (we) begin
        valid_r[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q_r <= mem[ra];
  end

  assign rq = qv_r ? q_r : '0;
endmodule

FILE: src/key_edge_hold_tap_chord_detector.sv
// key edge, hold, double-tap and chord detector
//
// in_ch carries one item per request: a frame tick with the raw key levels, or a
// hold, double-tap or chord query on key_a / key_b with a frame window.
// out_ch returns exactly one result item per accepted item, in order.
// per-key records (hold counter, tap history, chord history) sit in a small
// record memory with one read and one write port; a sequencer walks it.
// a frame tick visits one key per cycle and writes back its updated record;
// hold queries read key_a's record; double-tap and chord queries read their keys
// and clear that history on a hit; invalid queries go to the result. in_ch.ready
// is high only while the sequencer is idle, so one item is in flight at a time.
// the result waits in an output register; while out_ch.ready is low the block
// still finishes its current item and holds it until the register frees.
// synchronous reset clears levels, sequencer and output valid; the record
// memory reads as all zero for every key until a key is first written.
module key_edge_hold_tap_chord_detector #(
  parameter int NUM_KEYS = 16,
  parameter int HISTORY_LEN = 32
) (
  input logic         clk,
  input logic         rst_n,
  kehtc_in_if.sink    in_ch,
  kehtc_out_if.source out_ch
);
  import kehtc_pkg::*;

  localparam int KW = $clog2(NUM_KEYS);
  localparam int CW = $clog2(NUM_KEYS + 1);
  localparam int HL = HISTORY_LEN;
  localparam int RW = HOLD_W + 2 * HL;
  localparam int EW = (NUM_KEYS > LEVEL_W) ? NUM_KEYS : LEVEL_W;
  localparam logic [KEY_W-1:0] NK8 = KEY_W'(NUM_KEYS);
  localparam logic [KEY_W-1:0] HL8 = KEY_W'(HISTORY_LEN);
  localparam logic [CW-1:0] CNT_END = CW'(NUM_KEYS);
  localparam logic [LEVEL_W-1:0] LVL_MASK = (NUM_KEYS >= LEVEL_W) ? '1 :
                                            LEVEL_W'((64'd1 << NUM_KEYS) - 64'd1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TICK = 8'b0000_0010,
    S_QRD  = 8'b0000_0100,
    S_QA   = 8'b0000_1000,
    S_QB   = 8'b0001_0000,
    S_WRA  = 8'b0010_0000,
    S_WRB  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  req_t               req_r, req_nxt;
  logic [KEY_W-1:0]   ka_r, ka_nxt, kb_r, kb_nxt, w_r, w_nxt;
  logic [LEVEL_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, cnt_m1;
  logic               hit_r, hit_nxt, status_r, status_nxt, ca_r, ca_nxt;
  logic [RW-1:0]      wa_rec_r, wa_rec_nxt, wb_rec_r, wb_rec_nxt;

  logic               out_valid_r, out_valid_nxt, out_hit_r, out_status_r;
  logic [LEVEL_W-1:0] out_pe_r, out_re_r, out_hk_r;
  logic               load;

  logic [KW-1:0]      rd_addr, wr_addr;
  logic               we;
  logic [RW-1:0]      wd, rq;

  logic [HOLD_W-1:0]  rq_hold;
  logic [HL-1:0]      rq_tap, rq_chord, win_mask, tap_win;
  logic [LEVEL_W-1:0] press16, held16;
  logic [EW-1:0]      press_x, held_x;
  logic [NUM_KEYS-1:0] press_k, held_k;
  logic [HOLD_W-1:0]  new_hold;
  logic [RW-1:0]      tick_rec;
  logic               accept, req_bad;
  req_t               in_req;

  kehtc_store #(.NUM_KEYS(NUM_KEYS), .RW(RW)) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .ra   (rd_addr),
    .we   (we),
    .wa   (wr_addr),
    .wd   (wd),
    .rq   (rq)
  );

  assign in_req  = req_t'(in_ch.req_type);
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept  = in_ch.valid && (state_r == S_IDLE);

  assign rq_hold  = rq[HOLD_W-1:0];
  assign rq_tap   = rq[HOLD_W +: HL];
  assign rq_chord = rq[HOLD_W + HL +: HL];

  assign press16 = cur_r & ~prev_r;
  assign held16  = cur_r & prev_r;
  assign press_x = EW'(press16);
  assign held_x  = EW'(held16);
  assign press_k = press_x[NUM_KEYS-1:0];
  assign held_k  = held_x[NUM_KEYS-1:0];
  assign cnt_m1  = cnt_r - CW'(1);

  always_comb begin
    for (int i = 0; i < HL; i++) begin
      win_mask[i] = (KEY_W'(i) < w_r);
    end
  end

  assign tap_win = rq_tap & win_mask;

  // saturating hold count and one-frame history shift for the key being visited
  always_comb begin
    if (held_k[cnt_m1[KW-1:0]]) begin
      new_hold = (rq_hold == HOLD_MAX) ? rq_hold : rq_hold + HOLD_W'(1);
    end else begin
      new_hold = '0;
    end
    tick_rec = {rq_chord[HL-2:0], press_k[cnt_m1[KW-1:0]],
                rq_tap[HL-2:0], press_k[cnt_m1[KW-1:0]], new_hold};
  end

  always_comb begin
    unique case (in_req)
      REQ_HOLD:  req_bad = (in_ch.key_a >= NK8) || (in_ch.wait_frames == '0);
      REQ_TAP:   req_bad = (in_ch.key_a >= NK8) || (in_ch.wait_frames <= KEY_W'(1)) ||
                           (in_ch.wait_frames >= HL8);
      REQ_CHORD: req_bad = (in_ch.key_a >= NK8) || (in_ch.key_b >= NK8) ||
                           (in_ch.key_a == in_ch.key_b) || (in_ch.wait_frames == '0) ||
                           (in_ch.wait_frames > HL8);
      default:   req_bad = 1'b0;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_TICK:  rd_addr = cnt_r[KW-1:0];
      S_QRD:   rd_addr = ka_r[KW-1:0];
      S_QA:    rd_addr = kb_r[KW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = '0;
    wd      = tick_rec;
    unique case (state_r)
      S_TICK: begin
        we      = (cnt_r != '0);
        wr_addr = cnt_m1[KW-1:0];
        wd      = tick_rec;
      end
      S_WRA: begin
        we      = 1'b1;
        wr_addr = ka_r[KW-1:0];
        wd      = wa_rec_r;
      end
      S_WRB: begin
        we      = 1'b1;
        wr_addr = kb_r[KW-1:0];
        wd      = wb_rec_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    ka_nxt     = ka_r;
    kb_nxt     = kb_r;
    w_nxt      = w_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    cnt_nxt    = cnt_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    ca_nxt     = ca_r;
    wa_rec_nxt = wa_rec_r;
    wb_rec_nxt = wb_rec_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt    = in_req;
          ka_nxt     = in_ch.key_a;
          kb_nxt     = in_ch.key_b;
          w_nxt      = in_ch.wait_frames;
          hit_nxt    = 1'b0;
          status_nxt = req_bad;
          cnt_nxt    = '0;
          if (in_req == REQ_TICK) begin
            prev_nxt  = cur_r;
            cur_nxt   = in_ch.key_levels & LVL_MASK;
            state_nxt = S_TICK;
          end else if (req_bad) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_QRD;
          end
        end
      end
      S_TICK: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_END) begin
          state_nxt = S_DONE;
        end
      end
      S_QRD: begin
        state_nxt = S_QA;
      end
      S_QA: begin
        unique case (req_r)
          REQ_HOLD: begin
            hit_nxt   = (rq_hold >= w_r);
            state_nxt = S_DONE;
          end
          REQ_TAP: begin
            // two or more presses in the window
            if ((tap_win & (tap_win - HL'(1))) != '0) begin
              hit_nxt    = 1'b1;
              wa_rec_nxt = {rq_chord, {HL{1'b0}}, rq_hold};
              state_nxt  = S_WRA;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            ca_nxt     = ((rq_chord & win_mask) != '0);
            wa_rec_nxt = {{HL{1'b0}}, rq_tap, rq_hold};
            state_nxt  = S_QB;
          end
        endcase
      end
      S_QB: begin
        if (ca_r && ((rq_chord & win_mask) != '0)) begin
          hit_nxt    = 1'b1;
          wb_rec_nxt = {{HL{1'b0}}, rq_tap, rq_hold};
          state_nxt  = S_WRA;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WRA: begin
        state_nxt = (req_r == REQ_CHORD) ? S_WRB : S_DONE;
      end
      S_WRB: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      prev_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    ka_r     <= ka_nxt;
    kb_r     <= kb_nxt;
    w_r      <= w_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    ca_r     <= ca_nxt;
    wa_rec_r <= wa_rec_nxt;
    wb_rec_r <= wb_rec_nxt;
    if (load) begin
      out_hit_r    <= hit_r;
      out_status_r <= status_r;
      if (req_r == REQ_TICK) begin
        out_pe_r <= press16;
        out_re_r <= prev_r & ~cur_r;
        out_hk_r <= held16;
      end else begin
        out_pe_r <= '0;
        out_re_r <= '0;
        out_hk_r <= '0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = out_hit_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.pressed_edges  = out_pe_r;
  assign out_ch.released_edges = out_re_r;
  assign out_ch.held_keys      = out_hk_r;
endmodule
